/* src/rapa_pkg.sv */
// Package with the types, constants and register codes of the ring argument pool allocator.
package rapa_pkg;

    // Offset and alignment geometry of the pool.
    localparam int OFFSET_BITS = 20;
    localparam int ALIGN_BYTES = 64;
    // Alignment must be a power of two; rounding is done with shifts.
    localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
    // A size or a pool length may reach 2^OFFSET_BITS, so it needs one more bit.
    localparam int SIZE_BITS   = OFFSET_BITS + 1;
    // Offset plus size never overflows at this width.
    localparam int SUM_BITS    = OFFSET_BITS + 2;
    localparam int REQ_BITS    = 20;
    localparam int POOL_BITS   = 21;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [SIZE_BITS-1:0] ALIGN_ROUND = SIZE_BITS'(ALIGN_BYTES - 1);
    localparam logic [POOL_BITS-1:0] POOL_LIMIT  = POOL_BITS'(64'd1 << OFFSET_BITS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_SIZE    = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_ENABLED = 1'd1;

    typedef enum logic [0:0] {
        OP_ALLOC   = 1'b0,
        OP_RECYCLE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [REQ_BITS-1:0]  request_size;
        logic [REQ_BITS-1:0]  release_pos;
        logic                 release_skip;
    } req_t;

    typedef struct packed {
        logic                   ok;
        logic [OFFSET_BITS-1:0] start_pos;
        logic [OFFSET_BITS-1:0] end_pos;
        logic [OFFSET_BITS-1:0] head_pos;
        logic [OFFSET_BITS-1:0] tail_pos;
    } rsp_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] head;
        logic [OFFSET_BITS-1:0] tail;
    } ring_state_t;

    typedef struct packed {
        logic [POOL_BITS-1:0] pool_size;
        logic                 pool_enabled;
    } pool_cfg_t;

endpackage

/* src/rapa_core.sv */
// Combinational allocate and recycle decision for one transaction of the ring pool.
module rapa_core (
    input  rapa_pkg::req_t      item,
    input  rapa_pkg::ring_state_t state,
    input  rapa_pkg::pool_cfg_t cfg,
    output rapa_pkg::ring_state_t state_next,
    output rapa_pkg::rsp_t      result
);

    logic [rapa_pkg::SIZE_BITS-1:0] size_sum;
    logic [rapa_pkg::SIZE_BITS-1:0] size_aligned;
    logic [rapa_pkg::POOL_BITS-1:0] pool_clamped;
    logic [rapa_pkg::SUM_BITS-1:0]  tail_ext;
    logic [rapa_pkg::SUM_BITS-1:0]  head_ext;
    logic [rapa_pkg::SUM_BITS-1:0]  tail_plus;
    logic [rapa_pkg::SUM_BITS-1:0]  size_ext;
    logic [rapa_pkg::OFFSET_BITS-1:0] alloc_base;
    logic [rapa_pkg::SUM_BITS-1:0]  alloc_end;
    logic head_le_tail;
    logic fit_tail;
    logic fit_wrap;
    logic fit_gap;
    logic alloc_ok;
    logic in_span;
    logic in_wrap;
    logic rel_below_pool;

    // Round the request up to the alignment by masking off the low bits.
    assign size_sum     = rapa_pkg::SIZE_BITS'(item.request_size) + rapa_pkg::ALIGN_ROUND;
    assign size_aligned = (size_sum >> rapa_pkg::ALIGN_SHIFT) << rapa_pkg::ALIGN_SHIFT;

    assign pool_clamped = (cfg.pool_size > rapa_pkg::POOL_LIMIT) ? rapa_pkg::POOL_LIMIT
                                                                  : cfg.pool_size;

    assign tail_ext  = rapa_pkg::SUM_BITS'(state.tail);
    assign head_ext  = rapa_pkg::SUM_BITS'(state.head);
    assign size_ext  = rapa_pkg::SUM_BITS'(size_aligned);
    assign tail_plus = tail_ext + size_ext;

    assign head_le_tail = (state.head <= state.tail);
    assign fit_tail = head_le_tail && (tail_plus < rapa_pkg::SUM_BITS'(pool_clamped));
    assign fit_wrap = head_le_tail && (size_ext < head_ext);
    assign fit_gap  = !head_le_tail && (tail_plus < head_ext);
    assign alloc_ok = fit_tail || fit_wrap || fit_gap;

    // A wrap restarts the allocation at offset zero.
    assign alloc_base = (!fit_tail && fit_wrap) ? '0 : state.tail;
    assign alloc_end  = rapa_pkg::SUM_BITS'(alloc_base) + size_ext;

    // The recycle window check uses the unclamped pool size.
    assign rel_below_pool = (rapa_pkg::POOL_BITS'(item.release_pos) < cfg.pool_size);
    assign in_span = (state.head < state.tail) && (item.release_pos > state.head) &&
                     (item.release_pos <= state.tail);
    assign in_wrap = (state.head > state.tail) &&
                     ((item.release_pos <= state.tail) ||
                      ((item.release_pos > state.head) && rel_below_pool));

    always_comb
    begin
        state_next       = state;
        result.ok        = 1'b0;
        result.start_pos = '0;
        result.end_pos   = '0;
        if (item.op == rapa_pkg::OP_ALLOC)
        begin
            if (alloc_ok)
            begin
                result.ok        = 1'b1;
                result.start_pos = alloc_base;
                result.end_pos   = alloc_end[rapa_pkg::OFFSET_BITS-1:0];
                state_next.tail  = alloc_end[rapa_pkg::OFFSET_BITS-1:0];
            end
        end
        else
        begin
            if (item.release_skip || !cfg.pool_enabled)
            begin
                result.ok = 1'b1;
            end
            else if (in_span || in_wrap)
            begin
                result.ok       = 1'b1;
                state_next.head = item.release_pos;
            end
        end
        result.head_pos = state_next.head;
        result.tail_pos = state_next.tail;
    end

endmodule

/* src/ring_argument_pool_allocator_top.sv */
// Top level of the ring argument pool allocator: handshake, state and configuration registers.
// An accepted transaction waits in the input register; its result is then held in the result register.
// Throughput: one transaction per cycle while rsp_stall is low; the only loop is the head/tail update.
// Each stage holds one transaction, so one request can still be taken while a result stalls.
// Reset (rst_n low, asynchronous) empties both registers, sets head and tail to zero,
// sets the pool size to zero and marks the pool as disabled.
module ring_argument_pool_allocator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  rapa_pkg::req_t                      req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output rapa_pkg::rsp_t                      rsp_data,
    input  logic                                cfg_we,
    input  logic [rapa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [rapa_pkg::POOL_BITS-1:0]      cfg_data
);

    // Input stage: one accepted request transaction waiting for evaluation.
    logic               in_valid_reg;
    rapa_pkg::req_t     in_item_reg;

    // Result stage: one finished response transaction.
    logic               out_valid_reg;
    rapa_pkg::rsp_t     out_item_reg;

    // Ring offsets and configuration.
    rapa_pkg::ring_state_t ring_reg;
    rapa_pkg::ring_state_t ring_next;
    rapa_pkg::pool_cfg_t   cfg_reg;
    rapa_pkg::rsp_t        result_next;

    logic out_free;
    logic advance;
    logic in_free;

    // The result register can take a new value when it is empty or being drained.
    assign out_free = !out_valid_reg || !rsp_stall;
    // The input transaction is evaluated and retired when the result slot is free.
    assign advance  = in_valid_reg && out_free;
    // The input register can load when it is empty or its contents move on.
    assign in_free  = !in_valid_reg || advance;

    assign req_stall = !in_free;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_item_reg;

    // The decision uses the ring state left by the previous transaction, which has
    // already been written back at the edge that retired it.
    rapa_core u_core (
        .item       (in_item_reg),
        .state      (ring_reg),
        .cfg        (cfg_reg),
        .state_next (ring_next),
        .result     (result_next)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ring_reg      <= '0;
        end
        else
        begin
            if (in_free)
            begin
                in_valid_reg <= req_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                ring_reg <= ring_next;
            end
        end
    end

    // Configuration registers; writes must arrive only while the block is idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rapa_pkg::CFG_POOL_SIZE:    cfg_reg.pool_size    <= cfg_data;
                rapa_pkg::CFG_POOL_ENABLED: cfg_reg.pool_enabled <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_free && req_valid)
        begin
            in_item_reg <= req_data;
        end
        if (advance)
        begin
            out_item_reg <= result_next;
        end
    end

endmodule
